// ----- hdl/running_sample_statistics_defines.svh -----
// Assertion macros shared by the running sample statistics modules.
`ifndef RUNNING_SAMPLE_STATISTICS_DEFINES_SVH
`define RUNNING_SAMPLE_STATISTICS_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rss assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define RSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rss assertion failed");

`endif

// ----- hdl/rss_pkg.sv -----
// Types, codes and helper functions of the running sample statistics block.
package rss_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_BURN_IN      = 3'd0;
  localparam logic [2:0] REG_THIN_STEP    = 3'd1;
  localparam logic [2:0] REG_OFFSET       = 3'd2;
  localparam logic [2:0] REG_COLUMN_COUNT = 3'd3;
  localparam logic [2:0] REG_SCALE0       = 3'd4;
  localparam logic [2:0] REG_SCALE1       = 3'd5;
  localparam logic [2:0] REG_SCALE2       = 3'd6;
  localparam logic [2:0] REG_SCALE3       = 3'd7;

  // Datapath operations issued by the controller.
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE       = 4'd0;
  localparam op_t OP_LOAD       = 4'd1;
  localparam op_t OP_MUL        = 4'd2;
  localparam op_t OP_SCALE      = 4'd3;
  localparam op_t OP_SQ         = 4'd4;
  localparam op_t OP_MOD_START  = 4'd5;
  localparam op_t OP_DIV_STEP   = 4'd6;
  localparam op_t OP_KEEP       = 4'd7;
  localparam op_t OP_INIT       = 4'd8;
  localparam op_t OP_MEAN_START = 4'd9;
  localparam op_t OP_MEAN_FIN   = 4'd10;
  localparam op_t OP_VAR_START  = 4'd11;
  localparam op_t OP_VAR_FIN    = 4'd12;
  localparam op_t OP_EMIT       = 4'd13;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic past_burn;
    logic div_busy;
    logic kept_now;
    logic n_one;
    logic out_free;
  } status_t;

  // One store entry per element.
  typedef struct packed {
    logic signed [31:0] mean;
    logic [63:0]        ss;
    logic signed [31:0] mn;
    logic signed [31:0] mx;
  } entry_t;

  // Column of an element for a column count of 1 to 4.
  function automatic logic [1:0] col_of(input logic [5:0] e, input logic [2:0] cc);
    logic [12:0] p;
    logic [5:0]  q;
    logic [7:0]  r;
    p = 13'(e) * 13'd43;
    q = p[12:7];
    r = 8'(e) - 8'(q) * 8'd3;
    case (cc)
      3'd2:    col_of = {1'b0, e[0]};
      3'd3:    col_of = r[1:0];
      3'd4:    col_of = e[1:0];
      default: col_of = 2'd0;
    endcase
  endfunction

endpackage

// ----- hdl/rss_if.sv -----
// Handshake channels of the running sample statistics block.
interface rss_sample_if;
  logic               valid;
  logic               ready;
  logic [5:0]         element_index;
  logic signed [31:0] sample_value;
  logic               end_of_sweep;
  modport source (output valid, element_index, sample_value, end_of_sweep, input ready);
  modport sink (input valid, element_index, sample_value, end_of_sweep, output ready);
endinterface

interface rss_stats_if;
  logic               valid;
  logic               ready;
  logic               kept;
  logic signed [31:0] scaled_value;
  logic signed [31:0] running_mean;
  logic [30:0]        running_variance;
  logic signed [31:0] running_min;
  logic signed [31:0] running_max;
  logic [31:0]        kept_samples;
  modport source (output valid, kept, scaled_value, running_mean, running_variance,
                  running_min, running_max, kept_samples, input ready);
  modport sink (input valid, kept, scaled_value, running_mean, running_variance,
                running_min, running_max, kept_samples, output ready);
endinterface

interface rss_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/rss_ctrl.sv -----
// Sequencer that steps the statistics datapath through one item.
module rss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  rss_pkg::status_t status,
  output rss_pkg::op_t     op,
  output logic             in_ready
);
  import rss_pkg::*;
  `include "running_sample_statistics_defines.svh"

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL      = 4'd1;
  localparam logic [3:0] S_SCALE    = 4'd2;
  localparam logic [3:0] S_SQ       = 4'd3;
  localparam logic [3:0] S_MODST    = 4'd4;
  localparam logic [3:0] S_MODDIV   = 4'd5;
  localparam logic [3:0] S_KEEP     = 4'd6;
  localparam logic [3:0] S_INIT     = 4'd7;
  localparam logic [3:0] S_MEANST   = 4'd8;
  localparam logic [3:0] S_MEANDIV  = 4'd9;
  localparam logic [3:0] S_MEANFIN  = 4'd10;
  localparam logic [3:0] S_VARST    = 4'd11;
  localparam logic [3:0] S_VARDIV   = 4'd12;
  localparam logic [3:0] S_VARFIN   = 4'd13;
  localparam logic [3:0] S_DONE     = 4'd14;

  logic [3:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    op = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op = OP_LOAD;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        op = OP_MUL;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        op = OP_SCALE;
        state_next = S_SQ;
      end
      S_SQ: begin
        op = OP_SQ;
        state_next = status.past_burn ? S_MODST : S_DONE;
      end
      S_MODST: begin
        op = OP_MOD_START;
        state_next = S_MODDIV;
      end
      S_MODDIV: begin
        if (status.div_busy) op = OP_DIV_STEP;
        else state_next = S_KEEP;
      end
      S_KEEP: begin
        op = OP_KEEP;
        if (!status.kept_now) state_next = S_DONE;
        else if (status.n_one) state_next = S_INIT;
        else state_next = S_MEANST;
      end
      S_INIT: begin
        op = OP_INIT;
        state_next = S_DONE;
      end
      S_MEANST: begin
        op = OP_MEAN_START;
        state_next = S_MEANDIV;
      end
      S_MEANDIV: begin
        if (status.div_busy) op = OP_DIV_STEP;
        else state_next = S_MEANFIN;
      end
      S_MEANFIN: begin
        op = OP_MEAN_FIN;
        state_next = S_VARST;
      end
      S_VARST: begin
        op = OP_VAR_START;
        state_next = S_VARDIV;
      end
      S_VARDIV: begin
        if (status.div_busy) op = OP_DIV_STEP;
        else state_next = S_VARFIN;
      end
      S_VARFIN: begin
        op = OP_VAR_FIN;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          op = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Every emitted result returns the sequencer to idle.
  `RSS_ASSERT_NEXT(a_emit_to_idle, op == OP_EMIT, state == S_IDLE)
  // A divide stage only moves on once the divider has finished.
  `RSS_ASSERT_NOW(a_div_wait, (state == S_MODDIV || state == S_VARDIV) && status.div_busy,
                  op == OP_DIV_STEP)

endmodule

// ----- hdl/rss_dp.sv -----
// Datapath: configuration, scaling, shared divider, element store and result register.
module rss_dp #(
  parameter int NUM_ELEMENTS = 64,
  parameter int MAX_COLUMNS  = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  rss_pkg::op_t       op,
  output rss_pkg::status_t   status,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [5:0]         element_index,
  input  logic signed [31:0] sample_value,
  input  logic               end_of_sweep,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kept,
  output logic signed [31:0] out_scaled,
  output logic signed [31:0] out_mean,
  output logic [30:0]        out_var,
  output logic signed [31:0] out_min,
  output logic signed [31:0] out_max,
  output logic [31:0]        out_count
);
  import rss_pkg::*;
  `include "running_sample_statistics_defines.svh"

  localparam int AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam logic [2:0] MaxCc = 3'(MAX_COLUMNS);

  // Configuration registers.
  logic [31:0]        burn_in;
  logic [15:0]        thin_step;
  logic signed [31:0] offset;
  logic [2:0]         column_count;
  logic signed [15:0] scale [4];

  // Sweep state.
  logic [31:0] sweep_number, kept_count;

  // Item registers.
  logic [5:0]         eidx;
  logic signed [31:0] sample;
  logic               eos;
  logic [AW-1:0]      slot;
  logic [31:0]        n;
  logic signed [47:0] prod;
  logic signed [31:0] scaled;
  logic [63:0]        sq;
  logic               kept;
  entry_t             rd, wr;
  logic               dneg;
  logic signed [63:0] mm;
  logic [30:0]        var_q;
  logic [30:0]        var_q_r;

  // Shared restoring divider, one quotient bit per cycle.
  logic [63:0] quo;
  logic [31:0] rem, dvs;
  logic [6:0]  cnt;

  entry_t mem [NUM_ELEMENTS];

  // Element slot for every possible index, fixed at elaboration.
  logic [AW-1:0] slot_tab [64];
  for (genvar g = 0; g < 64; g++) begin : g_slot
    assign slot_tab[g] = AW'(g % NUM_ELEMENTS);
  end

  logic [2:0]         cc_eff;
  logic [15:0]        step_eff;
  logic signed [39:0] prod_div;
  logic signed [40:0] scaled_wide;
  logic signed [31:0] scaled_sat;
  logic [32:0]        div_t;
  logic               div_ge;
  logic signed [32:0] dsub;
  logic [32:0]        dabs;
  logic [64:0]        ss_sum;
  logic signed [33:0] qsig;
  logic signed [34:0] mean_sum;
  logic [63:0]        var_diff;
  logic [47:0]        var_sh;

  always_comb begin
    cc_eff = column_count;
    if (column_count == 3'd0) cc_eff = 3'd1;
    else if (column_count > MaxCc) cc_eff = MaxCc;
    step_eff = (thin_step == 16'd0) ? 16'd1 : thin_step;

    // Truncating divide by 256, then offset and saturation.
    prod_div = (prod < 0) ? 40'((prod + 48'sd255) >>> 8) : 40'(prod >>> 8);
    scaled_wide = 41'(prod_div) + 41'(offset);
    if (scaled_wide > 41'sd2147483647) scaled_sat = 32'sh7FFFFFFF;
    else if (scaled_wide < -41'sd2147483648) scaled_sat = 32'sh80000000;
    else scaled_sat = 32'(scaled_wide);

    div_t  = {rem, quo[63]};
    div_ge = (div_t >= {1'b0, dvs});

    dsub = 33'(scaled) - 33'(rd.mean);
    dabs = dsub[32] ? 33'(-dsub) : 33'(dsub);
    ss_sum = {1'b0, rd.ss} + {1'b0, sq};

    // Floor quotient of the mean difference, corrected toward zero at the end.
    if (!dneg) qsig = 34'(quo[32:0]);
    else if (rem != 32'd0) qsig = -34'(quo[32:0]) - 34'sd1;
    else qsig = -34'(quo[32:0]);
    mean_sum = 35'(rd.mean) + 35'(qsig);
    if (mean_sum < 0 && rem != 32'd0) mean_sum = mean_sum + 35'sd1;

    var_diff = (quo > 64'(mm)) ? quo - 64'(mm) : 64'd0;
    var_sh = var_diff[63:16];
    var_q = (var_sh > 48'h7FFFFFFF) ? 31'h7FFFFFFF : var_sh[30:0];
  end

  assign status.past_burn = (sweep_number > burn_in);
  assign status.div_busy  = (cnt != 7'd0);
  assign status.kept_now  = (rem == 32'd0);
  assign status.n_one     = (n == 32'd1);
  assign status.out_free  = !out_valid || out_ready;

  // Configuration and sweep counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      burn_in <= '0;
      thin_step <= 16'd1;
      offset <= '0;
      column_count <= 3'd1;
      for (int i = 0; i < 4; i++) scale[i] <= 16'sd256;
      sweep_number <= 32'd1;
      kept_count <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_BURN_IN:      burn_in <= cfg_data;
          REG_THIN_STEP:    thin_step <= cfg_data[15:0];
          REG_OFFSET:       offset <= cfg_data;
          REG_COLUMN_COUNT: column_count <= cfg_data[2:0];
          REG_SCALE0:       scale[0] <= cfg_data[15:0];
          REG_SCALE1:       scale[1] <= cfg_data[15:0];
          REG_SCALE2:       scale[2] <= cfg_data[15:0];
          REG_SCALE3:       scale[3] <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (op == OP_EMIT && eos) begin
        if (kept && kept_count != 32'hFFFFFFFF) kept_count <= kept_count + 32'd1;
        sweep_number <= sweep_number + 32'd1;
      end
    end
  end

  // Divider control.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (op)
        OP_MOD_START:  cnt <= 7'd32;
        OP_MEAN_START: cnt <= 7'd33;
        OP_VAR_START:  cnt <= 7'd64;
        OP_DIV_STEP:   cnt <= cnt - 7'd1;
        default: ;
      endcase
    end
  end

  // Item datapath.
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        eidx <= element_index;
        sample <= sample_value;
        eos <= end_of_sweep;
        kept <= 1'b0;
        n <= (kept_count == 32'hFFFFFFFF) ? kept_count : kept_count + 32'd1;
      end
      OP_MUL: begin
        slot <= slot_tab[eidx];
      end
      OP_SCALE: begin
        scaled <= scaled_sat;
      end
      OP_MOD_START: begin
        quo <= {sweep_number - burn_in - 32'd1, 32'd0};
        rem <= '0;
        dvs <= 32'(step_eff);
      end
      OP_DIV_STEP: begin
        quo <= {quo[62:0], div_ge};
        rem <= div_ge ? 32'(div_t - {1'b0, dvs}) : div_t[31:0];
      end
      OP_KEEP: kept <= (rem == 32'd0);
      OP_INIT: begin
        wr <= '{mean: scaled, ss: sq, mn: scaled, mx: scaled};
        var_q_r <= '0;
      end
      OP_MEAN_START: begin
        dneg <= dsub[32];
        quo <= {dabs, 31'd0};
        rem <= '0;
        dvs <= n;
        wr.ss <= ss_sum[64] ? 64'hFFFFFFFFFFFFFFFF : ss_sum[63:0];
        wr.mn <= (scaled < rd.mn) ? scaled : rd.mn;
        wr.mx <= (scaled > rd.mx) ? scaled : rd.mx;
      end
      OP_MEAN_FIN: wr.mean <= 32'(mean_sum);
      OP_VAR_START: begin
        mm <= 64'(wr.mean) * 64'(wr.mean);
        quo <= wr.ss;
        rem <= '0;
        dvs <= n;
      end
      OP_VAR_FIN: var_q_r <= var_q;
      default: ;
    endcase
    // The product sits in its own register ahead of the scaling logic.
    if (op == OP_MUL) prod <= 48'(scale[col_of(eidx, cc_eff)]) * 48'(sample);
    if (op == OP_SQ) sq <= 64'(scaled) * 64'(scaled);
  end

  // Element store with registered read.
  always_ff @(posedge clk) begin
    if (op == OP_SCALE) rd <= mem[slot];
    if (op == OP_INIT) mem[slot] <= '{mean: scaled, ss: sq, mn: scaled, mx: scaled};
    if (op == OP_VAR_FIN) mem[slot] <= wr;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT) begin
      out_kept <= kept;
      out_scaled <= scaled;
      out_mean <= kept ? wr.mean : '0;
      out_var <= kept ? var_q_r : '0;
      out_min <= kept ? wr.mn : '0;
      out_max <= kept ? wr.mx : '0;
      out_count <= kept ? n : kept_count;
    end
  end

  // The kept count only ever steps up by one.
  `RSS_ASSERT_NEXT(a_kept_count_step, !rst,
                   kept_count == $past(kept_count) || kept_count == $past(kept_count) + 32'd1)
  // A sweep that is not kept reports empty statistics.
  `RSS_ASSERT_NOW(a_unkept_empty, out_valid && !out_kept,
                  out_mean == '0 && out_var == '0 && out_min == '0 && out_max == '0)
  // The first kept sample sets mean, min and max to itself.
  `RSS_ASSERT_NOW(a_first_sample, out_valid && out_kept && out_count == 32'd1,
                  out_mean == out_scaled && out_min == out_scaled && out_max == out_scaled)

endmodule

// ----- hdl/running_sample_statistics.sv -----
// Top level of the running sample statistics block.
//
//  channel   direction  carries
//  samples   in         element_index, sample_value, end_of_sweep
//  stats     out        kept, scaled_value, running_mean/variance/min/max, kept_samples
//  cfg       in         index, data (register write, always ready)
//
// One item at a time through a shared one-bit-per-cycle divider.
// An item not past burn-in skips the divider; a discarded sweep and a first kept
// sample run only the thinning divide, and a later kept sample also divides for
// the mean and the square-sum average.
// Reset is synchronous; the element store holds no reset value.
// A new item is taken while the previous result waits; a stalled result holds the
// next one in its final stage.
module running_sample_statistics #(
  parameter int NUM_ELEMENTS = 64,
  parameter int MAX_COLUMNS  = 4
) (
  input logic       clk,
  input logic       rst,
  rss_sample_if.sink  samples,
  rss_stats_if.source stats,
  rss_cfg_if.sink     cfg
);
  import rss_pkg::*;

  op_t     op;
  status_t status;
  logic    in_ready;

  assign samples.ready = in_ready;
  assign cfg.ready = 1'b1;

  rss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .status   (status),
    .op       (op),
    .in_ready (in_ready)
  );

  rss_dp #(
    .NUM_ELEMENTS (NUM_ELEMENTS),
    .MAX_COLUMNS  (MAX_COLUMNS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .status        (status),
    .cfg_valid     (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .element_index (samples.element_index),
    .sample_value  (samples.sample_value),
    .end_of_sweep  (samples.end_of_sweep),
    .out_valid     (stats.valid),
    .out_ready     (stats.ready),
    .out_kept      (stats.kept),
    .out_scaled    (stats.scaled_value),
    .out_mean      (stats.running_mean),
    .out_var       (stats.running_variance),
    .out_min       (stats.running_min),
    .out_max       (stats.running_max),
    .out_count     (stats.kept_samples)
  );

endmodule
